// ===== design/jac_pkg.sv =====
package jac_pkg;

    localparam int ADC_BITS_DEFAULT = 10;
    localparam int AXIS_W           = 8;
    localparam int DEAD_W           = 7;
    localparam int CFG_IDX_W        = 2;
    localparam int NUM_W            = 15;
    localparam int DIV_STEPS        = NUM_W;
    localparam int STEP_W           = 4;

    localparam logic [6:0] SCALE_FULL = 7'd100;

    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MAX    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_CENTRE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND   = 2'd3;

    function automatic logic signed [7:0] median3(
        input logic signed [7:0] a,
        input logic signed [7:0] b,
        input logic signed [7:0] c
    );
        logic signed [7:0] m;
        m = c;
        if (a < c) begin
            if (b < c) begin
                m = (a > b) ? a : b;
            end
        end else if (b > c) begin
            m = (a < b) ? a : b;
        end
        return m;
    endfunction

endpackage

// ===== design/joystick_axis_conditioner_top.sv =====
// A transaction passes the clamp, setup, 15-step divide and done states;
// divide is skipped if the sample falls in the dead band or the span is zero.
// One item is handled at a time; o_stall is high outside the idle state.
// A new item is taken while a finished result still waits at the output.
// Synchronous active-low reset restores the register defaults and clears history.
module joystick_axis_conditioner_top
    import jac_pkg::*;
#(
    parameter int ADC_BITS = ADC_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [ADC_BITS-1:0]   i_raw_sample,
    input  logic                  i_button_level,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [7:0]     o_axis_angle,
    output logic                  o_button_pressed,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [AXIS_W-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLAMP,
        S_SETUP,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;

    logic [AXIS_W-1:0] r_axis_min;
    logic [AXIS_W-1:0] r_axis_max;
    logic [AXIS_W-1:0] r_axis_centre;
    logic [DEAD_W-1:0] r_dead_band;

    logic [AXIS_W-1:0]       r_sample;
    logic                    r_button;
    logic signed [8:0]       r_ax;
    logic [AXIS_W-1:0]       r_den;
    logic                    r_neg;
    logic                    r_zero;
    logic [AXIS_W-1:0]       r_rem;
    logic [NUM_W-1:0]        r_quo;
    logic [STEP_W-1:0]       r_step;
    logic signed [7:0]       r_newest;
    logic signed [7:0]       r_older;
    logic                    r_out_valid;
    logic signed [7:0]       r_out_angle;
    logic                    r_out_button;

    logic [AXIS_W-1:0]  clamped;
    logic signed [9:0]  dz_ext;
    logic signed [9:0]  lo_sum;
    logic signed [9:0]  hi_diff;
    logic signed [9:0]  lo_mag;
    logic signed [9:0]  den_lo;
    logic signed [9:0]  den_hi;
    logic signed [9:0]  den_sel;
    logic signed [9:0]  den_mag;
    logic               side_lo;
    logic               side_hi;
    logic [AXIS_W-1:0]  num_mag;
    logic [NUM_W-1:0]   product;
    logic [8:0]         shifted;
    logic [9:0]         trial;
    logic [6:0]         sat_mag;
    logic signed [7:0]  scaled;
    logic               out_free;
    logic               in_take;

    assign o_stall          = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_out_valid;
    assign o_axis_angle     = r_out_angle;
    assign o_button_pressed = r_out_button;

    assign in_take  = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        if (r_sample < r_axis_min) begin
            clamped = r_axis_min;
        end else if (r_sample > r_axis_max) begin
            clamped = r_axis_max;
        end else begin
            clamped = r_sample;
        end

        dz_ext  = $signed({3'b000, r_dead_band});
        lo_sum  = 10'(r_ax) + dz_ext;
        hi_diff = 10'(r_ax) - dz_ext;
        lo_mag  = -lo_sum;
        side_lo = lo_sum[9];
        side_hi = !hi_diff[9] && (hi_diff != 10'sd0);
        den_lo  = $signed({2'b00, r_axis_centre}) - $signed({2'b00, r_axis_min});
        den_hi  = $signed({2'b00, r_axis_max}) - $signed({2'b00, r_axis_centre});
        den_sel = side_lo ? den_lo : den_hi;
        den_mag = den_sel[9] ? -den_sel : den_sel;
        num_mag = side_lo ? lo_mag[7:0] : hi_diff[7:0];
        product = NUM_W'(num_mag) * NUM_W'(SCALE_FULL);

        shifted = {r_rem, r_quo[NUM_W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_den};

        sat_mag = (r_quo > NUM_W'(SCALE_FULL)) ? SCALE_FULL : r_quo[6:0];
        if (r_zero) begin
            scaled = 8'sd0;
        end else if (r_neg) begin
            scaled = -$signed({1'b0, sat_mag});
        end else begin
            scaled = $signed({1'b0, sat_mag});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_axis_min    <= 8'd0;
            r_axis_max    <= 8'd255;
            r_axis_centre <= 8'd128;
            r_dead_band   <= 7'd0;
            r_newest      <= 8'sd0;
            r_older       <= 8'sd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_AXIS_MIN:    r_axis_min    <= i_cfg_data;
                    CFG_AXIS_MAX:    r_axis_max    <= i_cfg_data;
                    CFG_AXIS_CENTRE: r_axis_centre <= i_cfg_data;
                    CFG_DEAD_BAND:   r_dead_band   <= i_cfg_data[DEAD_W-1:0];
                    default:         ;
                endcase
            end

            if (r_out_valid && !i_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_sample <= i_raw_sample[ADC_BITS-1 -: AXIS_W];
                        r_button <= i_button_level;
                        r_state  <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    r_ax    <= $signed({1'b0, clamped}) - $signed({1'b0, r_axis_centre});
                    r_state <= S_SETUP;
                end
                S_SETUP: begin
                    r_den  <= den_mag[7:0];
                    r_neg  <= side_lo ^ den_sel[9];
                    r_rem  <= '0;
                    r_quo  <= product;
                    r_step <= '0;
                    if ((!side_lo && !side_hi) || (den_sel == 10'sd0)) begin
                        r_zero  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_zero  <= 1'b0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (trial[9]) begin
                        r_rem <= shifted[7:0];
                    end else begin
                        r_rem <= trial[7:0];
                    end
                    r_quo  <= {r_quo[NUM_W-2:0], !trial[9]};
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_angle  <= median3(r_newest, r_older, scaled);
                        r_out_button <= !r_button;
                        r_older      <= r_newest;
                        r_newest     <= scaled;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
